### rtl/usd_pkg.sv
`default_nettype none
package usd_pkg;

  localparam int IN_BITS       = 16;
  localparam int OUT_FRAC_BITS = 14;
  localparam int OUT_W         = OUT_FRAC_BITS + 2;

  // Square root of a 64-bit radicand, one result bit per stage.
  localparam int SQRT_STAGES  = 32;
  localparam int CORDIC_STEPS = 30;

  // Input register, root stages, gain multiply, rotation stages, output register.
  localparam int LATENCY = SQRT_STAGES + CORDIC_STEPS + 3;

  // Inverse CORDIC gain in Q31.
  localparam logic [30:0] INV_GAIN_Q31 = 31'd1304065748;

  // Arctangent of 2^-i in units of 2^-32 turn.
  localparam logic [31:0] TURN_ATAN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef struct packed {
    logic [IN_BITS-1:0] height_fraction;
    logic [IN_BITS-1:0] azimuth_fraction;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] dir_x;
    logic signed [OUT_W-1:0] dir_y;
    logic signed [OUT_W-1:0] dir_z;
  } out_item_t;

  // Round a Q31 value to the output format, ties upward, and saturate to +-1.
  function automatic logic signed [OUT_W-1:0] to_output(input logic signed [33:0] v);
    logic signed [34:0] t;
    logic signed [34:0] one;
    begin
      one = 35'sd1 <<< OUT_FRAC_BITS;
      t = 35'(v) + (35'sd1 <<< (30 - OUT_FRAC_BITS));
      t = t >>> (31 - OUT_FRAC_BITS);
      if (t > one) begin
        t = one;
      end
      if (t < -one) begin
        t = -one;
      end
      return t[OUT_W-1:0];
    end
  endfunction

  // Height fraction to the z component.
  function automatic logic signed [OUT_W-1:0] height_to_z(input logic [IN_BITS-1:0] h);
    logic [31:0]        h32;
    logic signed [33:0] zq;
    begin
      h32 = 32'(h) << (32 - IN_BITS);
      zq  = (34'sd1 <<< 31) - $signed({2'b00, h32});
      return to_output(zq);
    end
  endfunction

endpackage
`default_nettype wire

### rtl/usd_isqrt.sv
`default_nettype none
// Pipelined integer square root: floor(sqrt(n)), one result bit per stage.
module usd_isqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_vld,
  input  wire logic [63:0] in_n,
  output logic             out_vld,
  output logic [31:0]      out_root
);

  logic        vld_r [usd_pkg::SQRT_STAGES];
  logic [63:0] rem_r [usd_pkg::SQRT_STAGES];
  logic [63:0] res_r [usd_pkg::SQRT_STAGES];

  for (genvar k = 0; k < usd_pkg::SQRT_STAGES; k++) begin : g_stage
    localparam logic [63:0] STEP_BIT = 64'(1) << (62 - 2 * k);
    logic        vld_in;
    logic [63:0] rem_in;
    logic [63:0] res_in;
    logic [63:0] trial;
    logic [63:0] rem_nxt;
    logic [63:0] res_nxt;

    if (k == 0) begin : g_first
      assign vld_in = in_vld;
      assign rem_in = in_n;
      assign res_in = '0;
    end else begin : g_next
      assign vld_in = vld_r[k-1];
      assign rem_in = rem_r[k-1];
      assign res_in = res_r[k-1];
    end

    always_comb begin
      trial = res_in + STEP_BIT;
      if (rem_in >= trial) begin
        rem_nxt = rem_in - trial;
        res_nxt = (res_in >> 1) + STEP_BIT;
      end else begin
        rem_nxt = rem_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
      rem_r[k] <= rem_nxt;
      res_r[k] <= res_nxt;
    end
  end

  assign out_vld  = vld_r[usd_pkg::SQRT_STAGES-1];
  assign out_root = res_r[usd_pkg::SQRT_STAGES-1][31:0];

endmodule
`default_nettype wire

### rtl/usd_cordic.sv
`default_nettype none
// Pipelined rotation-mode CORDIC, one micro-rotation per stage.
module usd_cordic (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_vld,
  input  wire logic signed [33:0] in_x,
  input  wire logic               in_neg,
  input  wire logic signed [32:0] in_ang,
  output logic                    out_vld,
  output logic signed [33:0]      out_x,
  output logic signed [33:0]      out_y
);

  logic               vld_r [usd_pkg::CORDIC_STEPS];
  logic signed [33:0] x_r   [usd_pkg::CORDIC_STEPS];
  logic signed [33:0] y_r   [usd_pkg::CORDIC_STEPS];
  logic signed [32:0] ang_r [usd_pkg::CORDIC_STEPS];

  for (genvar i = 0; i < usd_pkg::CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [32:0] ATAN = $signed({1'b0, usd_pkg::TURN_ATAN[i]});
    logic               vld_in;
    logic signed [33:0] x_in;
    logic signed [33:0] y_in;
    logic signed [32:0] ang_in;
    logic signed [33:0] x_nxt;
    logic signed [33:0] y_nxt;
    logic signed [32:0] ang_nxt;

    if (i == 0) begin : g_first
      // The half-turn fold flips the start vector.
      assign vld_in = in_vld;
      assign x_in   = in_neg ? -in_x : in_x;
      assign y_in   = '0;
      assign ang_in = in_ang;
    end else begin : g_next
      assign vld_in = vld_r[i-1];
      assign x_in   = x_r[i-1];
      assign y_in   = y_r[i-1];
      assign ang_in = ang_r[i-1];
    end

    always_comb begin
      if (!ang_in[32]) begin
        x_nxt   = x_in - (y_in >>> i);
        y_nxt   = y_in + (x_in >>> i);
        ang_nxt = ang_in - ATAN;
      end else begin
        x_nxt   = x_in + (y_in >>> i);
        y_nxt   = y_in - (x_in >>> i);
        ang_nxt = ang_in + ATAN;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
      x_r[i]   <= x_nxt;
      y_r[i]   <= y_nxt;
      ang_r[i] <= ang_nxt;
    end
  end

  assign out_vld = vld_r[usd_pkg::CORDIC_STEPS-1];
  assign out_x   = x_r[usd_pkg::CORDIC_STEPS-1];
  assign out_y   = y_r[usd_pkg::CORDIC_STEPS-1];

endmodule
`default_nettype wire

### rtl/uniform_sphere_direction.sv
// Uniform direction on the unit sphere. A request (height and azimuth fractions) is taken
// in every clock cycle in which start is high; busy never rises. Each request yields one
// direction on out_data, marked by a one-cycle out_valid strobe, in request order. The
// latency is set by the pipelined square root (32 stages, one root bit each) and the 30
// CORDIC rotation stages, plus the input register, the gain multiply and the output
// register. The receiver cannot stall the block, so a result must be captured in the
// cycle its strobe is high.
`default_nettype none
module uniform_sphere_direction (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire usd_pkg::in_item_t in_data,
  output logic                   out_valid,
  output usd_pkg::out_item_t     out_data
);

  localparam int ZDLY = usd_pkg::SQRT_STAGES + 1 + usd_pkg::CORDIC_STEPS;

  logic                             accept;
  logic [31:0]                      h32;
  logic [32:0]                      h_cmp;
  logic signed [32:0]               ang_raw;
  logic signed [32:0]               ang_fold;
  logic                             neg_fold;

  logic                             in_vld_r;
  logic [63:0]                      rad_r;
  logic signed [32:0]               ang_r;
  logic                             neg_r;
  logic signed [usd_pkg::OUT_W-1:0] z_r;

  logic signed [32:0]               ang_line_r [usd_pkg::SQRT_STAGES];
  logic                             neg_line_r [usd_pkg::SQRT_STAGES];
  logic signed [usd_pkg::OUT_W-1:0] z_line_r   [ZDLY];

  logic                             root_vld;
  logic [31:0]                      root;
  logic [61:0]                      gain_prod;
  logic                             gain_vld_r;
  logic signed [33:0]               gain_x_r;
  logic signed [32:0]               gain_ang_r;
  logic                             gain_neg_r;

  logic                             rot_vld;
  logic signed [33:0]               rot_x;
  logic signed [33:0]               rot_y;

  logic                             out_valid_r;
  usd_pkg::out_item_t               out_data_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Fold the azimuth into a quarter turn either side of zero.
  always_comb begin
    h32     = 32'(in_data.height_fraction) << (32 - usd_pkg::IN_BITS);
    h_cmp   = (33'd1 << 32) - {1'b0, h32};
    ang_raw = 33'($signed(32'(in_data.azimuth_fraction) << (32 - usd_pkg::IN_BITS)));
    if (ang_raw > (33'sd1 <<< 30)) begin
      ang_fold = ang_raw - (33'sd1 <<< 31);
      neg_fold = 1'b1;
    end else if (ang_raw < -(33'sd1 <<< 30)) begin
      ang_fold = ang_raw + (33'sd1 <<< 31);
      neg_fold = 1'b1;
    end else begin
      ang_fold = ang_raw;
      neg_fold = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= accept;
    end
    rad_r <= 64'(h32) * 64'(h_cmp);
    ang_r <= ang_fold;
    neg_r <= neg_fold;
    z_r   <= usd_pkg::height_to_z(in_data.height_fraction);
  end

  usd_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_vld_r),
    .in_n     (rad_r),
    .out_vld  (root_vld),
    .out_root (root)
  );

  // Side data that rides alongside the root stages.
  always_ff @(posedge clk) begin
    for (int k = 0; k < usd_pkg::SQRT_STAGES; k++) begin
      if (k == 0) begin
        ang_line_r[k] <= ang_r;
        neg_line_r[k] <= neg_r;
      end else begin
        ang_line_r[k] <= ang_line_r[k-1];
        neg_line_r[k] <= neg_line_r[k-1];
      end
    end
    for (int k = 0; k < ZDLY; k++) begin
      if (k == 0) begin
        z_line_r[k] <= z_r;
      end else begin
        z_line_r[k] <= z_line_r[k-1];
      end
    end
  end

  // Prescale the radius by the inverse CORDIC gain, rounded half up.
  assign gain_prod = 62'(root) * 62'(usd_pkg::INV_GAIN_Q31) + (62'd1 << 30);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_vld_r <= 1'b0;
    end else begin
      gain_vld_r <= root_vld;
    end
    gain_x_r   <= $signed({3'b000, gain_prod[62-1:31]});
    gain_ang_r <= ang_line_r[usd_pkg::SQRT_STAGES-1];
    gain_neg_r <= neg_line_r[usd_pkg::SQRT_STAGES-1];
  end

  usd_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (gain_vld_r),
    .in_x    (gain_x_r),
    .in_neg  (gain_neg_r),
    .in_ang  (gain_ang_r),
    .out_vld (rot_vld),
    .out_x   (rot_x),
    .out_y   (rot_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= rot_vld;
    end
    out_data_r.dir_x <= usd_pkg::to_output(rot_x);
    out_data_r.dir_y <= usd_pkg::to_output(rot_y);
    out_data_r.dir_z <= z_line_r[ZDLY-1];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

### rtl/usd_checker.sv
`default_nettype none
module usd_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire usd_pkg::in_item_t in_data,
  input wire logic              out_valid,
  input wire usd_pkg::out_item_t out_data
);

  localparam logic signed [usd_pkg::OUT_W-1:0] ONE =
    $signed({2'b01, {usd_pkg::OUT_FRAC_BITS{1'b0}}});

  // The receiver cannot push back, so the block must never refuse a request.
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy asserted");

  // Every result strobe traces back to a request taken a fixed latency earlier.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, usd_pkg::LATENCY))
    else $error("result without matching request");

  // The height maps straight to z, so z must match the request it came from.
  a_z_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      out_data.dir_z == usd_pkg::height_to_z($past(in_data.height_fraction,
                                                   usd_pkg::LATENCY)))
    else $error("dir_z does not match request height");

  // Horizontal components stay within the unit range after saturation.
  a_xy_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.dir_x <= ONE) && (out_data.dir_x >= -ONE) &&
                  (out_data.dir_y <= ONE) && (out_data.dir_y >= -ONE))
    else $error("dir_x or dir_y out of range");

endmodule

bind uniform_sphere_direction usd_checker u_usd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
`default_nettype wire
